// ----- sv/truth6_semicanonical_minimizer_assert.svh -----
// Assertion macros for the semi-canonical minimiser.
// Expects signals named clock and reset in the scope of use.
`ifndef TRUTH6_SEMICANONICAL_MINIMIZER_ASSERT_SVH
`define TRUTH6_SEMICANONICAL_MINIMIZER_ASSERT_SVH

// same-cycle implication
`define TSM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tsm assertion failed");

// next-cycle implication
`define TSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tsm assertion failed");

`endif

// ----- sv/tsm_pkg.sv -----
// Shared types, constants and table functions of the semi-canonical minimiser.
// No dependencies.
`timescale 1ns / 1ps

package tsm_pkg;

   localparam int VAR_COUNT = 6;
   localparam int VIDX_W    = 3;
   localparam logic [VIDX_W-1:0] PAIR_COUNT = 3'd5;

   localparam logic [63:0] SWAP_KEEP [5] = '{
      64'h9999999999999999, 64'hC3C3C3C3C3C3C3C3, 64'hF00FF00FF00FF00F,
      64'hFF0000FFFF0000FF, 64'hFFFF00000000FFFF
   };
   localparam logic [63:0] SWAP_UP [5] = '{
      64'h2222222222222222, 64'h0C0C0C0C0C0C0C0C, 64'h00F000F000F000F0,
      64'h0000FF000000FF00, 64'h00000000FFFF0000
   };
   localparam logic [63:0] SWAP_DOWN [5] = '{
      64'h4444444444444444, 64'h3030303030303030, 64'h0F000F000F000F00,
      64'h00FF000000FF0000, 64'h0000FFFF00000000
   };
   localparam logic [63:0] VAR_MASK [6] = '{
      64'hAAAAAAAAAAAAAAAA, 64'hCCCCCCCCCCCCCCCC, 64'hF0F0F0F0F0F0F0F0,
      64'hFF00FF00FF00FF00, 64'hFFFF0000FFFF0000, 64'hFFFFFFFF00000000
   };

   // choice per pair round; low two bits flip phase bits v and v+1
   typedef enum logic [2:0] {
      CH_KEEP          = 3'd0,
      CH_NEG_LO        = 3'd1,
      CH_NEG_HI        = 3'd2,
      CH_NEG_BOTH      = 3'd3,
      CH_SWAP          = 3'd4,
      CH_SWAP_NEG_HI   = 3'd5,
      CH_SWAP_NEG_LO   = 3'd6,
      CH_SWAP_NEG_BOTH = 3'd7
   } choice_type;

   typedef struct packed {
      logic              load;
      logic              pass_start;
      logic              stage1;
      logic              stage2;
      logic              apply;
      logic              load_out;
      logic [VIDX_W-1:0] v;
   } tsm_cmd_type;

   typedef struct packed {
      logic tie;
      logic changed;
   } tsm_status_type;

   function automatic logic [63:0] neg_var(input logic [63:0] t, input logic [VIDX_W-1:0] v);
      logic [63:0] r;
      r = t;
      for (int i = 0; i < VAR_COUNT; i++) begin
         if (v == VIDX_W'(i)) begin
            r = ((t & ~VAR_MASK[i]) << (1 << i)) | ((t & VAR_MASK[i]) >> (1 << i));
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] swap_adj(input logic [63:0] t, input logic [VIDX_W-1:0] v);
      logic [63:0] r;
      r = t;
      for (int i = 0; i < VAR_COUNT - 1; i++) begin
         if (v == VIDX_W'(i)) begin
            r = (t & SWAP_KEEP[i]) | ((t & SWAP_UP[i]) << (1 << i))
                | ((t & SWAP_DOWN[i]) >> (1 << i));
         end
      end
      return r;
   endfunction

endpackage

// ----- sv/tsm_stream_if.sv -----
// Valid/ready channels of the semi-canonical minimiser: request and response.
// No dependencies.
`timescale 1ns / 1ps

interface tsm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] truth_in;
   logic [4:0]  tie_mask;
   logic [17:0] perm_in;
   logic [6:0]  phase_in;

   modport source (output valid, truth_in, tie_mask, perm_in, phase_in, input ready);
   modport sink   (input valid, truth_in, tie_mask, perm_in, phase_in, output ready);
endinterface

interface tsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] truth_out;
   logic [17:0] perm_out;
   logic [6:0]  phase_out;

   modport source (output valid, truth_out, perm_out, phase_out, input ready);
   modport sink   (input valid, truth_out, perm_out, phase_out, output ready);
endinterface

// ----- sv/tsm_ctrl.sv -----
// Sequencer of the minimiser: walks passes and pair rounds, owns the handshakes.
// Depends on tsm_pkg.
`timescale 1ns / 1ps

module tsm_ctrl import tsm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output tsm_cmd_type    cmd,
   input  tsm_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE, S_PASS, S_SEL, S_CMP1, S_CMP2, S_CMP3, S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [VIDX_W-1:0] v_ff, v_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      v_in     = v_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PASS;
         end
         S_PASS: begin
            v_in     = '0;
            state_in = S_SEL;
         end
         S_SEL: begin
            if (v_ff == PAIR_COUNT) begin
               state_in = status.changed ? S_PASS : S_FINISH;
            end else if (status.tie) begin
               state_in = S_CMP1;
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         S_CMP1: state_in = S_CMP2;
         S_CMP2: state_in = S_CMP3;
         S_CMP3: begin
            v_in     = v_ff + 1'b1;
            state_in = S_SEL;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == S_IDLE) && req_valid;
      cmd.pass_start = (state_ff == S_PASS);
      cmd.stage1     = (state_ff == S_CMP1);
      cmd.stage2     = (state_ff == S_CMP2);
      cmd.apply      = (state_ff == S_CMP3);
      cmd.load_out   = (state_ff == S_FINISH) && out_free;
      cmd.v          = v_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v_ff         <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/tsm_dpath.sv -----
// Datapath of the minimiser: working table, permutation, phase, compare tree
// and response word register. Depends on tsm_pkg.
`timescale 1ns / 1ps

module tsm_dpath import tsm_pkg::*; (
   input  logic           clock,
   input  tsm_cmd_type    cmd,
   output tsm_status_type status,
   input  logic [63:0]    truth_in,
   input  logic [4:0]     tie_mask,
   input  logic [17:0]    perm_in,
   input  logic [6:0]     phase_in,
   output logic [63:0]    truth_out,
   output logic [17:0]    perm_out,
   output logic [6:0]     phase_out
);

   logic [63:0]           t_ff, before_ff;
   logic [VAR_COUNT-1:0][2:0] perm_ff, perm_new;
   logic [6:0]            phase_ff, phase_new;
   logic [4:0]            ties_ff;
   logic [7:0]            ties_ext;

   logic [63:0]           cand [8];
   choice_type            cand_code [8];
   logic [63:0]           sw, nhi, swnhi;

   logic [63:0]           s1_val_ff [4];
   choice_type            s1_code_ff [4];
   logic [63:0]           s2_val_ff [2];
   choice_type            s2_code_ff [2];
   logic [63:0]           best;
   choice_type            best_code;
   logic [VIDX_W-1:0]     vp1;

   logic [63:0]           truth_out_ff;
   logic [17:0]           perm_out_ff;
   logic [6:0]            phase_out_ff;

   assign vp1      = cmd.v + 1'b1;
   assign ties_ext = {3'b000, ties_ff};
   assign status.tie     = ties_ext[cmd.v];
   assign status.changed = (t_ff != before_ff);

   // the eight variants, in the order ties are resolved (earlier wins)
   always_comb begin
      sw    = swap_adj(t_ff, cmd.v);
      nhi   = neg_var(t_ff, vp1);
      swnhi = neg_var(sw, vp1);
      cand[0] = t_ff;                    cand_code[0] = CH_KEEP;
      cand[1] = neg_var(t_ff, cmd.v);    cand_code[1] = CH_NEG_LO;
      cand[2] = nhi;                     cand_code[2] = CH_NEG_HI;
      cand[3] = neg_var(nhi, cmd.v);     cand_code[3] = CH_NEG_BOTH;
      cand[4] = sw;                      cand_code[4] = CH_SWAP;
      cand[5] = neg_var(sw, cmd.v);      cand_code[5] = CH_SWAP_NEG_LO;
      cand[6] = swnhi;                   cand_code[6] = CH_SWAP_NEG_HI;
      cand[7] = neg_var(swnhi, cmd.v);   cand_code[7] = CH_SWAP_NEG_BOTH;
   end

   always_comb begin
      if (s2_val_ff[1] < s2_val_ff[0]) begin
         best      = s2_val_ff[1];
         best_code = s2_code_ff[1];
      end else begin
         best      = s2_val_ff[0];
         best_code = s2_code_ff[0];
      end
   end

   always_comb begin
      perm_new  = perm_ff;
      phase_new = phase_ff ^ (7'(best_code[1:0]) << cmd.v);
      if (best_code[2]) begin
         perm_new[cmd.v] = perm_ff[vp1];
         perm_new[vp1]   = perm_ff[cmd.v];
         // a swap exchanges the phase bits of the pair
         if (phase_new[cmd.v] != phase_new[vp1]) begin
            phase_new = phase_new ^ ((7'd1 << cmd.v) | (7'd1 << vp1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         t_ff     <= truth_in[63] ? ~truth_in : truth_in;
         phase_ff <= phase_in ^ {truth_in[63], 6'b000000};
         perm_ff  <= perm_in;
         ties_ff  <= tie_mask;
      end else if (cmd.apply) begin
         t_ff     <= best;
         phase_ff <= phase_new;
         perm_ff  <= perm_new;
      end
      if (cmd.pass_start) before_ff <= t_ff;
      if (cmd.stage1) begin
         for (int k = 0; k < 4; k++) begin
            if (cand[2*k+1] < cand[2*k]) begin
               s1_val_ff[k]  <= cand[2*k+1];
               s1_code_ff[k] <= cand_code[2*k+1];
            end else begin
               s1_val_ff[k]  <= cand[2*k];
               s1_code_ff[k] <= cand_code[2*k];
            end
         end
      end
      if (cmd.stage2) begin
         for (int k = 0; k < 2; k++) begin
            if (s1_val_ff[2*k+1] < s1_val_ff[2*k]) begin
               s2_val_ff[k]  <= s1_val_ff[2*k+1];
               s2_code_ff[k] <= s1_code_ff[2*k+1];
            end else begin
               s2_val_ff[k]  <= s1_val_ff[2*k];
               s2_code_ff[k] <= s1_code_ff[2*k];
            end
         end
      end
      if (cmd.load_out) begin
         truth_out_ff <= t_ff;
         perm_out_ff  <= perm_ff;
         phase_out_ff <= phase_ff;
      end
   end

   assign truth_out = truth_out_ff;
   assign perm_out  = perm_out_ff;
   assign phase_out = phase_out_ff;

endmodule

// ----- sv/truth6_semicanonical_minimizer.sv -----
// Semi-canonical minimiser for 6-input truth tables.
// req_chan carries one word: table, tie mask, permutation and phase. It is
// taken only while the block is idle (req_chan.ready high). rsp_chan returns
// one word per request: minimised table, permutation and phase.
// A table with its top bit set is complemented first (phase bit 6 toggles).
// Each pass visits pairs 0..4, between a pass set-up step and a final change
// check; a pair whose tie_mask bit is set also goes through the registered
// 8-to-1 compare tree (stage 1, stage 2, apply). Passes repeat until one
// leaves the table unchanged. The next word can be taken the cycle after the
// response is loaded; no new word is taken while one is being worked on.
// The response sits in its own register, so a stalled receiver holds it
// while the next word is already being worked on; the block then waits at
// the end of that word until the register is free.
// Synchronous reset returns to idle with no response pending.
`timescale 1ns / 1ps
`include "truth6_semicanonical_minimizer_assert.svh"

module truth6_semicanonical_minimizer import tsm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   tsm_req_if.sink    req_chan,
   tsm_rsp_if.source  rsp_chan
);

   tsm_cmd_type    cmd;
   tsm_status_type status;

   tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .status    (status)
   );

   tsm_dpath u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .truth_in  (req_chan.truth_in),
      .tie_mask  (req_chan.tie_mask),
      .perm_in   (req_chan.perm_in),
      .phase_in  (req_chan.phase_in),
      .truth_out (rsp_chan.truth_out),
      .perm_out  (rsp_chan.perm_out),
      .phase_out (rsp_chan.phase_out)
   );

   // busy right after taking a word
   `TSM_ASSERT_NEXT(a_busy_after_accept, req_chan.valid && req_chan.ready, !req_chan.ready)
   // compare tree only runs on a tied pair
   `TSM_ASSERT_IMP(a_round_on_tied_pair, cmd.stage1, status.tie)
   // minimum never exceeds the complemented start, so the top bit is clear
   `TSM_ASSERT_IMP(a_result_top_clear, rsp_chan.valid, !rsp_chan.truth_out[63])

endmodule
